/* sv/lom_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package lom_pkg;

  localparam int NUM_INSTRUMENTS  = 5;
  localparam int ENTRIES_PER_SIDE = 32;
  localparam int SLOT_W           = 5;
  localparam int SIDE_W           = 4;
  localparam int NUM_SIDES        = 16;
  localparam int NUM_SLOTS        = NUM_SIDES * (2 ** SLOT_W);
  localparam int MAX_RESULTS      = 64;

  localparam logic [2:0] ST_NEW     = 3'd0;
  localparam logic [2:0] ST_FILL    = 3'd1;
  localparam logic [2:0] ST_PARTIAL = 3'd2;
  localparam logic [2:0] ST_UNKNOWN = 3'd3;
  localparam logic [2:0] ST_FULL    = 3'd4;

  typedef struct packed {
    logic [2:0]  instrument;
    logic        side;
    logic [15:0] price_tick;
    logic [19:0] quantity;
    logic [31:0] client_id;
  } order_t;

  typedef struct packed {
    logic [31:0] report_order_id;
    logic [31:0] report_client_id;
    logic [2:0]  report_instrument;
    logic        report_side;
    logic [2:0]  status;
    logic [19:0] report_quantity;
    logic [15:0] report_price;
    logic        last;
  } report_t;

  typedef struct packed {
    logic [15:0] price;
    logic [19:0] quantity;
    logic [31:0] order_id;
    logic [31:0] client_id;
  } entry_t;

  typedef enum logic [1:0] {RD_NONE, RD_HEAD, RD_CUR, RD_PREV} rd_kind_t;
  typedef enum logic [2:0] {WR_NONE, WR_HEAD, WR_PREV, WR_CUR, WR_NEW} wr_kind_t;
  typedef enum logic [2:0] {EM_NONE, EM_REJ, EM_AGG, EM_RES, EM_NEW, EM_FULL} em_kind_t;
  typedef enum logic [2:0] {IX_HOLD, IX_ONE, IX_INC, IX_DEC, IX_CNT} ix_op_t;

  typedef struct packed {
    logic     load;
    logic     sel_opp;
    rd_kind_t rd;
    wr_kind_t wr;
    ix_op_t   ix;
    logic     trade;
    logic     cnt_inc;
    logic     cnt_dec;
    em_kind_t emit;
    logic     flush;
  } lom_cmd_t;

  typedef struct packed {
    logic unknown;
    logic qty_zero;
    logic cnt_zero;
    logic side_full;
    logic match;
    logic better;
    logic rq_zero;
    logic idx_lt_cnt;
    logic idx_zero;
    logic crossed;
    logic emit_ok;
  } lom_sts_t;

endpackage
`default_nettype wire

/* sv/lom_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
module lom_datapath import lom_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire order_t   in_data,
  input  wire lom_cmd_t cmd,
  output lom_sts_t      sts,
  output logic          out_valid,
  input  wire logic     out_ready,
  output report_t       out_data
);

  entry_t      mem [NUM_SLOTS];
  entry_t      rdata_r;
  order_t      ord_r;
  logic [19:0] qty_r, qty_nxt;
  logic [19:0] t_r, rq_r;
  logic [31:0] oid_r, next_id_r;
  logic        crossed_r;
  logic [6:0]  rpt_cnt_r;
  logic [5:0]  idx_r, idx_nxt;
  logic [5:0]  fill_r [NUM_SIDES];
  logic        pend_valid_r, out_valid_r;
  report_t     pend_r, out_r, em;
  logic [SIDE_W-1:0] side_idx;
  logic [5:0]  cnt;
  logic [5:0]  idx_m1;
  logic [SIDE_W+SLOT_W-1:0] raddr, waddr;
  entry_t      wdata;
  logic        wen, out_free, do_emit;
  logic [19:0] t_val;

  assign side_idx = {ord_r.instrument, ord_r.side ^ cmd.sel_opp};
  assign cnt      = fill_r[side_idx];
  assign idx_m1   = idx_r - 6'd1;
  assign out_free = !out_valid_r || out_ready;
  assign t_val    = (qty_r < rdata_r.quantity) ? qty_r : rdata_r.quantity;

  always_comb begin
    sts.unknown    = {1'b0, ord_r.instrument} >= 4'(NUM_INSTRUMENTS);
    sts.qty_zero   = qty_r == '0;
    sts.cnt_zero   = cnt == '0;
    sts.side_full  = cnt >= 6'(ENTRIES_PER_SIDE);
    sts.match      = ord_r.side ? (ord_r.price_tick <= rdata_r.price)
                                : (ord_r.price_tick >= rdata_r.price);
    sts.better     = ord_r.side ? (ord_r.price_tick < rdata_r.price)
                                : (ord_r.price_tick > rdata_r.price);
    sts.rq_zero    = rq_r == '0;
    sts.idx_lt_cnt = idx_r < cnt;
    sts.idx_zero   = idx_r == '0;
    sts.crossed    = crossed_r;
    sts.emit_ok    = !pend_valid_r || out_free;
  end

  always_comb begin
    unique case (cmd.rd)
      RD_HEAD: raddr = {side_idx, SLOT_W'(0)};
      RD_PREV: raddr = {side_idx, idx_m1[SLOT_W-1:0]};
      RD_CUR:  raddr = {side_idx, idx_r[SLOT_W-1:0]};
      default: raddr = {side_idx, SLOT_W'(0)};
    endcase
    wen   = 1'b1;
    wdata = rdata_r;
    waddr = {side_idx, idx_r[SLOT_W-1:0]};
    unique case (cmd.wr)
      WR_HEAD: begin
        waddr          = {side_idx, SLOT_W'(0)};
        wdata.quantity = rq_r;
      end
      WR_PREV: waddr = {side_idx, idx_m1[SLOT_W-1:0]};
      WR_CUR:  waddr = {side_idx, idx_r[SLOT_W-1:0]};
      WR_NEW: begin
        wdata.price     = ord_r.price_tick;
        wdata.quantity  = qty_r;
        wdata.order_id  = oid_r;
        wdata.client_id = ord_r.client_id;
      end
      default: wen = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[waddr] <= wdata;
    end
    if (cmd.rd != RD_NONE) begin
      rdata_r <= mem[raddr];
    end
  end

  always_comb begin
    em                   = '0;
    em.report_order_id   = oid_r;
    em.report_client_id  = ord_r.client_id;
    em.report_instrument = ord_r.instrument;
    em.report_side       = ord_r.side;
    em.report_quantity   = qty_r;
    em.report_price      = ord_r.price_tick;
    unique case (cmd.emit)
      EM_REJ: begin
        em.report_order_id = '0;
        em.status          = ST_UNKNOWN;
      end
      EM_AGG: begin
        em.status          = (qty_r == '0) ? ST_FILL : ST_PARTIAL;
        em.report_quantity = t_r;
        em.report_price    = rdata_r.price;
      end
      EM_RES: begin
        em.report_order_id  = rdata_r.order_id;
        em.report_client_id = rdata_r.client_id;
        em.report_side      = !ord_r.side;
        em.status           = (rq_r == '0) ? ST_FILL : ST_PARTIAL;
        em.report_quantity  = t_r;
        em.report_price     = rdata_r.price;
      end
      EM_NEW:  em.status = ST_NEW;
      EM_FULL: em.status = ST_FULL;
      default: em.status = ST_NEW;
    endcase
    do_emit = (cmd.emit != EM_NONE) && (rpt_cnt_r < 7'(MAX_RESULTS));
  end

  always_comb begin
    qty_nxt = cmd.trade ? (qty_r - t_val) : qty_r;
    unique case (cmd.ix)
      IX_ONE:  idx_nxt = 6'd1;
      IX_INC:  idx_nxt = idx_r + 6'd1;
      IX_DEC:  idx_nxt = idx_m1;
      IX_CNT:  idx_nxt = cnt;
      default: idx_nxt = idx_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ord_r <= in_data;
      qty_r <= in_data.quantity;
      oid_r <= next_id_r;
    end else begin
      qty_r <= qty_nxt;
    end
    if (cmd.trade) begin
      t_r  <= t_val;
      rq_r <= rdata_r.quantity - t_val;
    end
    idx_r <= idx_nxt;
    if (do_emit) begin
      pend_r <= em;
    end
    if (do_emit && pend_valid_r) begin
      out_r      <= pend_r;
    end else if (cmd.flush && pend_valid_r) begin
      out_r      <= {pend_r[$bits(report_t)-1:1], 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r    <= 32'd1;
      crossed_r    <= 1'b0;
      rpt_cnt_r    <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int i = 0; i < NUM_SIDES; i++) begin
        fill_r[i] <= '0;
      end
    end else begin
      if (cmd.load) begin
        crossed_r <= 1'b0;
        rpt_cnt_r <= '0;
        if ({1'b0, in_data.instrument} < 4'(NUM_INSTRUMENTS)) begin
          next_id_r <= next_id_r + 32'd1;
        end
      end
      if (cmd.trade) begin
        crossed_r <= 1'b1;
      end
      if (cmd.cnt_inc) begin
        fill_r[side_idx] <= cnt + 6'd1;
      end else if (cmd.cnt_dec) begin
        fill_r[side_idx] <= cnt - 6'd1;
      end
      if (do_emit) begin
        rpt_cnt_r    <= rpt_cnt_r + 7'd1;
        pend_valid_r <= 1'b1;
      end else if (cmd.flush && pend_valid_r) begin
        pend_valid_r <= 1'b0;
      end
      if ((do_emit || cmd.flush) && pend_valid_r) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

/* sv/lom_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module lom_ctrl import lom_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire lom_sts_t sts,
  output lom_cmd_t      cmd
);

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_REJ, S_MRD, S_MWAIT, S_AGG, S_RES, S_RMRD, S_RMWR,
    S_REST, S_INSRD, S_INSWAIT, S_INSWR, S_NEW, S_FULL, S_FLUSH
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = state_r == S_IDLE;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: state_nxt = sts.unknown ? S_REJ : S_MRD;
      S_REJ: begin
        if (sts.emit_ok) begin
          cmd.emit  = EM_REJ;
          state_nxt = S_FLUSH;
        end
      end
      S_MRD: begin
        cmd.sel_opp = 1'b1;
        if (sts.qty_zero || sts.cnt_zero) begin
          state_nxt = S_REST;
        end else begin
          cmd.rd    = RD_HEAD;
          state_nxt = S_MWAIT;
        end
      end
      S_MWAIT: begin
        if (sts.match) begin
          cmd.trade = 1'b1;
          state_nxt = S_AGG;
        end else begin
          state_nxt = S_REST;
        end
      end
      S_AGG: begin
        if (sts.emit_ok) begin
          cmd.emit  = EM_AGG;
          state_nxt = S_RES;
        end
      end
      S_RES: begin
        cmd.sel_opp = 1'b1;
        if (sts.emit_ok) begin
          cmd.emit = EM_RES;
          if (sts.rq_zero) begin
            cmd.ix    = IX_ONE;
            state_nxt = S_RMRD;
          end else begin
            cmd.wr    = WR_HEAD;
            state_nxt = S_MRD;
          end
        end
      end
      S_RMRD: begin
        cmd.sel_opp = 1'b1;
        if (sts.idx_lt_cnt) begin
          cmd.rd    = RD_CUR;
          state_nxt = S_RMWR;
        end else begin
          cmd.cnt_dec = 1'b1;
          state_nxt   = S_MRD;
        end
      end
      S_RMWR: begin
        cmd.sel_opp = 1'b1;
        cmd.wr      = WR_PREV;
        cmd.ix      = IX_INC;
        state_nxt   = S_RMRD;
      end
      S_REST: begin
        if (sts.qty_zero) begin
          state_nxt = S_FLUSH;
        end else if (sts.side_full) begin
          state_nxt = S_FULL;
        end else begin
          cmd.ix    = IX_CNT;
          state_nxt = S_INSRD;
        end
      end
      S_INSRD: begin
        if (sts.idx_zero) begin
          state_nxt = S_INSWR;
        end else begin
          cmd.rd    = RD_PREV;
          state_nxt = S_INSWAIT;
        end
      end
      S_INSWAIT: begin
        if (sts.better) begin
          cmd.wr    = WR_CUR;
          cmd.ix    = IX_DEC;
          state_nxt = S_INSRD;
        end else begin
          state_nxt = S_INSWR;
        end
      end
      S_INSWR: begin
        cmd.wr      = WR_NEW;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.crossed ? S_FLUSH : S_NEW;
      end
      S_NEW: begin
        if (sts.emit_ok) begin
          cmd.emit  = EM_NEW;
          state_nxt = S_FLUSH;
        end
      end
      S_FULL: begin
        if (sts.emit_ok) begin
          cmd.emit  = EM_FULL;
          state_nxt = S_FLUSH;
        end
      end
      S_FLUSH: begin
        if (sts.emit_ok) begin
          cmd.flush = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/limit_order_matcher.sv */
// One order at a time: a new order is taken only when the last is done. An order for an
// unknown instrument is rejected; others trade against the opposite book, each fill of a
// resting order shifts the later entries up, and a remainder is inserted in price order.
// Reports pass a one-word hold stage and an output register; the last word carries last.
// Synchronous reset clears all books to empty and sets the next order id to one;
// book memory contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module limit_order_matcher import lom_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire order_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output report_t     out_data
);

  lom_cmd_t cmd;
  lom_sts_t sts;

  lom_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  lom_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire
